>>> rtl/core/n2a_pkg.sv
// Shared types, codes and helpers of the number-to-ASCII formatter.
package n2a_pkg;

   // Opcode values of the request word.
   localparam logic [1:0] OP_SIGNED_DEC   = 2'd0;
   localparam logic [1:0] OP_UNSIGNED_DEC = 2'd1;
   localparam logic [1:0] OP_HEX          = 2'd2;
   localparam logic [1:0] OP_OCTAL        = 2'd3;

   // Longest digit string: eleven octal digits for 32 bits.
   localparam int NUM_DIGITS  = 11;
   localparam int DIGIT_IDX_W = 4;
   localparam int MAG_W       = 32;
   localparam int POS_W       = 5;

   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_SPACE   = 7'h20;
   localparam logic [6:0] CHAR_MINUS   = 7'h2D;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] number;
      logic [4:0]  field_width;
      logic        zero_pad;
   } n2a_req_type;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic       last_char;
   } n2a_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CONVERT,
      ST_SIGN,
      ST_EMIT
   } n2a_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic shift;
      logic step;
      logic sel_sign;
   } n2a_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_decimal;
      logic neg;
      logic conv_last;
      logic pos_last;
      logic pos_pad;
      logic natural;
   } n2a_status_type;

   function automatic logic [6:0] n2a_digit_char(input logic [3:0] digit);
      logic [6:0] result;
      if (digit > 4'd9) begin
         result = CHAR_UPPER_A + 7'(digit - 4'd10);
      end else begin
         result = CHAR_ZERO + 7'(digit);
      end
      return result;
   endfunction

endpackage

>>> rtl/core/n2a_datapath.sv
// Datapath: magnitude, digit register with binary-to-BCD shifter, position counter.
module n2a_datapath #(
   parameter int MAX_WIDTH = 16
) (
   input  logic                    clock,
   input  n2a_pkg::n2a_req_type    req_data,
   input  n2a_pkg::n2a_cmd_type    cmd,
   output n2a_pkg::n2a_status_type status,
   output n2a_pkg::n2a_rsp_type    rsp_data
);
   import n2a_pkg::*;

   logic [NUM_DIGITS-1:0][3:0] digits_ff, digits_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [POS_W-1:0]           cnt_ff, cnt_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       decimal_ff, decimal_in;
   logic                       neg_ff, neg_in;
   logic                       natural_ff, natural_in;
   logic                       zero_pad_ff, zero_pad_in;

   logic [POS_W-1:0]           width_sat;
   logic                       req_neg;
   logic [MAG_W:0]             octal_ext;
   logic [4*NUM_DIGITS-1:0]    hex_ext;
   logic [NUM_DIGITS-1:0][3:0] packed_digits;
   logic [NUM_DIGITS-1:0][3:0] adjusted;
   logic [3:0]                 cur_digit;
   logic                       upper_nonzero;
   logic                       cur_pad;

   always_comb begin
      if (int'(req_data.field_width) > MAX_WIDTH) begin
         width_sat = POS_W'(MAX_WIDTH);
      end else begin
         width_sat = req_data.field_width;
      end
      req_neg   = (req_data.opcode == OP_SIGNED_DEC) && req_data.number[MAG_W-1];
      octal_ext = {1'b0, req_data.number};
      hex_ext   = (4*NUM_DIGITS)'(req_data.number);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (req_data.opcode == OP_HEX) begin
            packed_digits[i] = hex_ext[4*i +: 4];
         end else begin
            packed_digits[i] = {1'b0, octal_ext[3*i +: 3]};
         end
      end
      // Add-three correction of each BCD digit before the next shift.
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adjusted[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
   end

   always_comb begin
      if (pos_ff < POS_W'(NUM_DIGITS)) begin
         cur_digit = digits_ff[pos_ff[DIGIT_IDX_W-1:0]];
      end else begin
         cur_digit = 4'd0;
      end
      upper_nonzero = 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if ((POS_W'(i) >= pos_ff) && (digits_ff[i] != 4'd0)) begin
            upper_nonzero = 1'b1;
         end
      end
      // A position is padding when it and every higher digit are zero,
      // except for the lowest position.
      cur_pad = (pos_ff != '0) && !upper_nonzero;
   end

   always_comb begin
      digits_in   = digits_ff;
      mag_in      = mag_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      decimal_in  = decimal_ff;
      neg_in      = neg_ff;
      natural_in  = natural_ff;
      zero_pad_in = zero_pad_ff;
      if (cmd.load) begin
         decimal_in  = (req_data.opcode == OP_SIGNED_DEC) ||
                       (req_data.opcode == OP_UNSIGNED_DEC);
         neg_in      = req_neg;
         natural_in  = (width_sat == '0);
         zero_pad_in = req_data.zero_pad;
         mag_in      = req_neg ? (MAG_W'(0) - req_data.number) : req_data.number;
         digits_in   = decimal_in ? '0 : packed_digits;
         cnt_in      = '0;
         pos_in      = natural_in ? POS_W'(NUM_DIGITS - 1) : width_sat - POS_W'(1);
      end else if (cmd.shift) begin
         digits_in = (4*NUM_DIGITS)'({adjusted[NUM_DIGITS-1:0], mag_ff[MAG_W-1]});
         mag_in    = {mag_ff[MAG_W-2:0], 1'b0};
         cnt_in    = cnt_ff + POS_W'(1);
      end else if (cmd.step) begin
         pos_in = pos_ff - POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      mag_ff      <= mag_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      decimal_ff  <= decimal_in;
      neg_ff      <= neg_in;
      natural_ff  <= natural_in;
      zero_pad_ff <= zero_pad_in;
   end

   always_comb begin
      status.is_decimal = decimal_ff;
      status.neg        = neg_ff;
      status.conv_last  = (cnt_ff == POS_W'(MAG_W - 1));
      status.pos_last   = (pos_ff == '0);
      status.pos_pad    = cur_pad;
      status.natural    = natural_ff;

      if (cmd.sel_sign) begin
         rsp_data.ascii_char = CHAR_MINUS;
      end else if (cur_pad) begin
         rsp_data.ascii_char = zero_pad_ff ? CHAR_ZERO : CHAR_SPACE;
      end else begin
         rsp_data.ascii_char = n2a_digit_char(cur_digit);
      end
      rsp_data.last_char = !cmd.sel_sign && (pos_ff == '0);
   end

endmodule

>>> rtl/core/n2a_ctrl.sv
// Controller state machine: accepts a word, runs conversion, walks the character positions.
module n2a_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  n2a_pkg::n2a_status_type status,
   output n2a_pkg::n2a_cmd_type    cmd
);
   import n2a_pkg::*;

   n2a_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.is_decimal) begin
               state_in = ST_CONVERT;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_last) begin
               state_in = status.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            cmd.sel_sign = 1'b1;
            rsp_valid    = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Leading padding is dropped without a word at natural length.
            if (status.natural && status.pos_pad) begin
               cmd.step = 1'b1;
            end else begin
               rsp_valid = 1'b1;
               if (!rsp_stall) begin
                  cmd.step = 1'b1;
                  if (status.pos_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/number_to_ascii_formatter.sv
// Top level of the number-to-ASCII formatter.
// The req_ channel takes one word holding an opcode (signed decimal, unsigned
// decimal, uppercase hex, octal), a 32-bit number, a field width and a
// zero-pad flag. The rsp_ channel returns one ASCII character per word, most
// significant first, with last_char set on the final character of the number.
// A negative signed value starts with '-', which is not counted in the width.
// One number is handled at a time; req_stall stays high from acceptance
// until its last character has been taken.
// Sequence: a dispatch state after acceptance, then for decimal opcodes a
// binary-to-BCD shift over all 32 bits (one bit of the number per cycle),
// then one character per cycle while rsp_stall is low. At natural width
// each leading zero position of the eleven-digit register is skipped
// without a character. Hex and octal skip the shift. A number gives up to
// MAX_WIDTH characters, plus the sign for a negative signed value.
// A stalled character holds with rsp_valid high until rsp_stall drops.
// Synchronous reset returns the controller to idle and drops any number in
// progress.
module number_to_ascii_formatter #(
   parameter int MAX_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  n2a_pkg::n2a_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output n2a_pkg::n2a_rsp_type rsp_data
);
   import n2a_pkg::*;

   n2a_cmd_type    cmd;
   n2a_status_type status;

   n2a_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   n2a_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // No new number is taken while characters are being sent.
   a_no_accept_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a character is pending");

   // After the final character is taken, the block is ready again.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_char) |=> !req_stall)
      else $error("block not idle after last character");

   // The sign never ends a number.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.ascii_char == CHAR_MINUS) |-> !rsp_data.last_char)
      else $error("sign marked as last character");

   // Conversion and character stepping never overlap.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.load, cmd.shift, cmd.step}) <= 1)
      else $error("conflicting datapath commands");

endmodule
